@@ design/tst_pkg.sv @@
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the TCP session tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package tst_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam logic [7:0] FL_FIN = 8'h01;
	localparam logic [7:0] FL_SYN = 8'h02;
	localparam logic [7:0] FL_RST = 8'h04;
	localparam logic [7:0] FL_ACK = 8'h10;

	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq_num;
		logic [31:0] ack_num;
		logic [7:0]  tcp_flags;
	} pkt_t;

	typedef struct packed {
		logic        status;
		logic [31:0] finished_count;
		logic [31:0] aborted_count;
		logic [6:0]  open_sessions;
	} res_t;

	// lookup pass kinds
	typedef enum logic [5:0] {
		K_NONE   = 6'b000001,
		K_FREE   = 6'b000010,
		K_SYNACK = 6'b000100,
		K_FIN    = 6'b001000,
		K_ACK    = 6'b010000,
		K_RST    = 6'b100000
	} kind_t;

	// classified item passed from front to back
	typedef struct packed {
		pkt_t  pkt;
		kind_t first;
		logic  rst_after;
	} work_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] src_port;
		logic [15:0] dst_port;
		logic [31:0] seq;
		logic [7:0]  flags;
		logic [31:0] stamp;
	} ent_t;

endpackage
`default_nettype wire

@@ design/tcp_session_tracker.sv @@
// ----------------------------------------------------------------------------
// tcp_session_tracker
// Follows TCP handshakes in a table of sessions; one result per header.
// ----------------------------------------------------------------------------
// Each header takes P lookup passes over the table: 0 for headers that touch
//   no stage, 1 usually, 2 when RST rides on SYN+ACK or FIN. The scan does one
//   table read per cycle; the back takes a new header only once the last is out.
// Reset clears all entry valid bits, counters and the insert stamp at once;
//   the table memory itself is not cleared.
`default_nettype none
module tcp_session_tracker #(
	parameter int ENTRIES = tst_pkg::ENTRIES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tst_pkg::pkt_t pkt,
	input  wire logic          pkt_valid,
	output logic               pkt_stall,
	output tst_pkg::res_t      res,
	output logic               res_valid,
	input  wire logic          res_stall
);

	// front to back: two-deep queue of classified items
	tst_pkg::work_t work;
	logic           work_valid;
	logic           work_pop;

	// front classifies flags into the first lookup pass and a pending RST pass
	tst_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pkt        (pkt),
		.pkt_valid  (pkt_valid),
		.pkt_stall  (pkt_stall),
		.work       (work),
		.work_valid (work_valid),
		.work_pop   (work_pop)
	);

	// back scans the table memory, oldest match wins (first free entry for a SYN), then writes or removes
	tst_back #(.ENTRIES(ENTRIES)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.work       (work),
		.work_valid (work_valid),
		.work_pop   (work_pop),
		.res        (res),
		.res_valid  (res_valid),
		.res_stall  (res_stall)
	);

endmodule
`default_nettype wire

@@ design/tst_ram.sv @@
// ----------------------------------------------------------------------------
// tst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

@@ design/tst_front.sv @@
// ----------------------------------------------------------------------------
// tst_front
// Accepts packet headers, classifies the flag byte, and queues the work.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tst_pkg::pkt_t pkt,
	input  wire logic          pkt_valid,
	output logic               pkt_stall,
	output tst_pkg::work_t     work,
	output logic               work_valid,
	input  wire logic          work_pop
);

	tst_pkg::work_t slot_q [2];
	logic           rd_ptr_q, wr_ptr_q;
	logic [1:0]     fill_q;
	tst_pkg::work_t cls;
	logic           push;
	logic [7:0]     fl;

	always_comb begin
		fl = pkt.tcp_flags;
		cls.pkt = pkt;
		cls.rst_after = 1'b0;
		if (fl == tst_pkg::FL_SYN) begin
			cls.first = tst_pkg::K_FREE;
		end else if ((fl & tst_pkg::FL_SYN) != 8'd0 && (fl & tst_pkg::FL_ACK) != 8'd0) begin
			cls.first = tst_pkg::K_SYNACK;
			cls.rst_after = (fl & tst_pkg::FL_RST) != 8'd0;
		end else if ((fl & tst_pkg::FL_FIN) != 8'd0) begin
			cls.first = tst_pkg::K_FIN;
			cls.rst_after = (fl & tst_pkg::FL_RST) != 8'd0;
		end else if (fl == tst_pkg::FL_ACK) begin
			cls.first = tst_pkg::K_ACK;
		end else if ((fl & tst_pkg::FL_RST) != 8'd0) begin
			cls.first = tst_pkg::K_RST;
		end else begin
			cls.first = tst_pkg::K_NONE;
		end
	end

	assign pkt_stall  = (fill_q == 2'd2);
	assign push       = pkt_valid && !pkt_stall;
	assign work_valid = (fill_q != 2'd0);
	assign work       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (work_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, work_pop};
		end
	end

endmodule
`default_nettype wire

@@ design/tst_back.sv @@
// ----------------------------------------------------------------------------
// tst_back
// Session table engine: scans the table once per lookup pass, applies the
// update, and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module tst_back #(
	parameter int ENTRIES = tst_pkg::ENTRIES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tst_pkg::work_t work,
	input  wire logic           work_valid,
	output logic                work_pop,
	output tst_pkg::res_t       res,
	output logic                res_valid,
	input  wire logic           res_stall
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OW = $clog2(ENTRIES + 1);
	localparam int EW = $bits(tst_pkg::ent_t);
	localparam logic [IW:0] CNT_END = (IW + 1)'(ENTRIES);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_APPLY = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	state_t          state_q;
	tst_pkg::kind_t  kind_q;
	logic            rst_q;
	tst_pkg::pkt_t   item_q;
	logic [IW:0]     cnt_q;
	logic            cmp_v_s1;
	logic [IW-1:0]   cmp_idx_s1;
	logic            found_q;
	logic [IW-1:0]   best_idx_q;
	logic [31:0]     best_age_q;
	logic [7:0]      best_flags_q;
	logic [ENTRIES-1:0] valid_q;
	logic [31:0]     stamp_q, fin_q, abt_q;
	logic [OW-1:0]   open_q;
	logic            status_q;
	tst_pkg::res_t   res_q;
	logic            res_valid_q;

	tst_pkg::ent_t   rd_ent, wr_ent;
	logic [EW-1:0]   rd_raw;
	logic            wr_en;
	logic            same, rev, fits, hit, cand, take;
	logic [31:0]     age;
	logic [7:0]      f;
	logic            do_store, do_remove;
	logic            scan_end;
	logic            res_load;

	tst_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (best_idx_q),
		.wr_data (wr_ent),
		.rd_addr (cnt_q[IW-1:0]),
		.rd_data (rd_raw)
	);

	assign rd_ent = tst_pkg::ent_t'(rd_raw);

	// match logic on the entry read back
	always_comb begin
		f    = rd_ent.flags;
		same = item_q.src_ip == rd_ent.src_ip && item_q.dst_ip == rd_ent.dst_ip &&
		       item_q.src_port == rd_ent.src_port && item_q.dst_port == rd_ent.dst_port;
		rev  = item_q.src_ip == rd_ent.dst_ip && item_q.dst_ip == rd_ent.src_ip &&
		       item_q.src_port == rd_ent.dst_port && item_q.dst_port == rd_ent.src_port;
		fits = item_q.ack_num == rd_ent.seq + 32'd1;
		age  = stamp_q - rd_ent.stamp;
		unique case (kind_q)
			tst_pkg::K_SYNACK: hit = f == tst_pkg::FL_SYN && rev && fits;
			tst_pkg::K_FIN:    hit = (f == tst_pkg::FL_ACK && (same || rev)) ||
			                         (f[0] && rev && fits);
			tst_pkg::K_ACK:    hit = ((f[1] && f[4]) || f[0]) && rev && fits;
			tst_pkg::K_RST:    hit = same || rev;
			default:           hit = 1'b0;
		endcase
		if (kind_q == tst_pkg::K_FREE) begin
			cand = !valid_q[cmp_idx_s1];
			take = cand && !found_q;
		end else begin
			cand = valid_q[cmp_idx_s1] && hit;
			take = cand && (!found_q || age > best_age_q);
		end
	end

	// update decision for the apply step
	always_comb begin
		do_store  = 1'b0;
		do_remove = 1'b0;
		if (state_q == S_APPLY && found_q) begin
			unique case (kind_q)
				tst_pkg::K_FREE, tst_pkg::K_SYNACK, tst_pkg::K_FIN: do_store = 1'b1;
				tst_pkg::K_ACK: begin
					do_remove = best_flags_q[0];
					do_store  = !best_flags_q[0];
				end
				tst_pkg::K_RST: do_remove = 1'b1;
				default: ;
			endcase
		end
		wr_en           = do_store;
		wr_ent.src_ip   = item_q.src_ip;
		wr_ent.dst_ip   = item_q.dst_ip;
		wr_ent.src_port = item_q.src_port;
		wr_ent.dst_port = item_q.dst_port;
		wr_ent.seq      = item_q.seq_num;
		wr_ent.flags    = item_q.tcp_flags;
		wr_ent.stamp    = stamp_q;
	end

	assign work_pop  = (state_q == S_IDLE) && work_valid;
	assign scan_end  = (cnt_q == CNT_END) && !cmp_v_s1;
	assign res_load  = (state_q == S_OUT) && (!res_valid_q || !res_stall);
	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk) begin
		if (work_pop) begin
			item_q <= work.pkt;
		end
		if (state_q == S_SCAN && cmp_v_s1 && take) begin
			best_idx_q   <= cmp_idx_s1;
			best_age_q   <= age;
			best_flags_q <= f;
		end
		cmp_idx_s1 <= cnt_q[IW-1:0];
		if (res_load) begin
			res_q.status         <= status_q;
			res_q.finished_count <= fin_q;
			res_q.aborted_count  <= abt_q;
			res_q.open_sessions  <= (open_q > OW'(127)) ? 7'd127 : 7'(open_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= tst_pkg::K_NONE;
			rst_q       <= 1'b0;
			cnt_q       <= '0;
			cmp_v_s1    <= 1'b0;
			found_q     <= 1'b0;
			valid_q     <= '0;
			stamp_q     <= '0;
			fin_q       <= '0;
			abt_q       <= '0;
			open_q      <= '0;
			status_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (work_pop) begin
						kind_q   <= work.first;
						rst_q    <= work.rst_after;
						status_q <= 1'b0;
						cnt_q    <= '0;
						found_q  <= 1'b0;
						cmp_v_s1 <= 1'b0;
						state_q  <= (work.first == tst_pkg::K_NONE) ? S_OUT : S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q != CNT_END) begin
						cnt_q    <= cnt_q + 1'b1;
						cmp_v_s1 <= 1'b1;
					end else begin
						cmp_v_s1 <= 1'b0;
					end
					if (cmp_v_s1 && take) begin
						found_q <= 1'b1;
					end
					if (scan_end) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (do_store) begin
						valid_q[best_idx_q] <= 1'b1;
						stamp_q <= stamp_q + 32'd1;
						if (!valid_q[best_idx_q]) begin
							open_q <= open_q + 1'b1;
						end
					end
					if (do_remove) begin
						valid_q[best_idx_q] <= 1'b0;
						open_q <= open_q - 1'b1;
						if (kind_q == tst_pkg::K_RST) begin
							abt_q <= abt_q + 32'd1;
						end else begin
							fin_q <= fin_q + 32'd1;
						end
					end
					if (kind_q == tst_pkg::K_FREE && !found_q) begin
						status_q <= 1'b1;
					end
					if (kind_q != tst_pkg::K_RST && rst_q) begin
						kind_q   <= tst_pkg::K_RST;
						rst_q    <= 1'b0;
						cnt_q    <= '0;
						found_q  <= 1'b0;
						cmp_v_s1 <= 1'b0;
						state_q  <= S_SCAN;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Session tracker check: random and directed TCP headers against a local
// model of the session table; one result per header compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

class session_scoreboard;
	localparam int N = tst_pkg::ENTRIES_DEF;

	bit          ent_valid [N];
	logic [31:0] ent_sip   [N];
	logic [31:0] ent_dip   [N];
	logic [15:0] ent_sp    [N];
	logic [15:0] ent_dp    [N];
	logic [31:0] ent_seq   [N];
	logic [7:0]  ent_fl    [N];
	logic [31:0] ent_stamp [N];
	logic [31:0] stamp_ctr;
	logic [31:0] fin_total;
	logic [31:0] abort_total;
	tst_pkg::res_t pending_results[$];
	int errors;

	function new();
		for (int i = 0; i < N; i++) ent_valid[i] = 0;
		stamp_ctr = 0;
		fin_total = 0;
		abort_total = 0;
		errors = 0;
	endfunction

	function bit same_dir(tst_pkg::pkt_t p, int i);
		return p.src_ip == ent_sip[i] && p.dst_ip == ent_dip[i] &&
			p.src_port == ent_sp[i] && p.dst_port == ent_dp[i];
	endfunction

	function bit rev_dir(tst_pkg::pkt_t p, int i);
		return p.src_ip == ent_dip[i] && p.dst_ip == ent_sip[i] &&
			p.src_port == ent_dp[i] && p.dst_port == ent_sp[i];
	endfunction

	// kind: 0 syn+ack, 1 fin, 2 plain ack, 3 rst
	function bit hit(tst_pkg::pkt_t p, int i, int kind);
		logic [7:0] f;
		logic [31:0] nxt;
		bit fits;
		f = ent_fl[i];
		nxt = ent_seq[i] + 32'd1;
		fits = p.ack_num == nxt;
		case (kind)
			0: return f == tst_pkg::FL_SYN && rev_dir(p, i) && fits;
			1: return (f == tst_pkg::FL_ACK && (same_dir(p, i) || rev_dir(p, i))) ||
				((f & tst_pkg::FL_FIN) != 0 && rev_dir(p, i) && fits);
			2: return ((((f & tst_pkg::FL_SYN) != 0) && ((f & tst_pkg::FL_ACK) != 0)) ||
				((f & tst_pkg::FL_FIN) != 0)) && rev_dir(p, i) && fits;
			default: return same_dir(p, i) || rev_dir(p, i);
		endcase
	endfunction

	function int oldest_hit(tst_pkg::pkt_t p, int kind);
		int best;
		logic [31:0] best_age, age;
		best = -1;
		best_age = 0;
		for (int i = 0; i < N; i++) begin
			if (ent_valid[i] && hit(p, i, kind)) begin
				age = stamp_ctr - ent_stamp[i];
				if (best < 0 || age > best_age) begin
					best = i;
					best_age = age;
				end
			end
		end
		return best;
	endfunction

	function void store(tst_pkg::pkt_t p, int i);
		ent_valid[i] = 1;
		ent_sip[i] = p.src_ip;
		ent_dip[i] = p.dst_ip;
		ent_sp[i] = p.src_port;
		ent_dp[i] = p.dst_port;
		ent_seq[i] = p.seq_num;
		ent_fl[i] = p.tcp_flags;
		ent_stamp[i] = stamp_ctr;
		stamp_ctr = stamp_ctr + 1;
	endfunction

	function void note_header(tst_pkg::pkt_t p);
		tst_pkg::res_t r;
		logic [7:0] f;
		int slot, cnt;
		f = p.tcp_flags;
		r = '0;
		if (f == tst_pkg::FL_SYN) begin
			slot = -1;
			for (int i = 0; i < N; i++)
				if (!ent_valid[i] && slot < 0) slot = i;
			if (slot < 0) r.status = 1;
			else store(p, slot);
		end else if ((f & tst_pkg::FL_SYN) != 0 && (f & tst_pkg::FL_ACK) != 0) begin
			slot = oldest_hit(p, 0);
			if (slot >= 0) store(p, slot);
		end else if ((f & tst_pkg::FL_FIN) != 0) begin
			slot = oldest_hit(p, 1);
			if (slot >= 0) store(p, slot);
		end
		if (f == tst_pkg::FL_ACK) begin
			slot = oldest_hit(p, 2);
			if (slot >= 0) begin
				if ((ent_fl[slot] & tst_pkg::FL_FIN) != 0) begin
					ent_valid[slot] = 0;
					fin_total = fin_total + 1;
				end else begin
					store(p, slot);
				end
			end
		end
		if ((f & tst_pkg::FL_RST) != 0) begin
			slot = oldest_hit(p, 3);
			if (slot >= 0) begin
				ent_valid[slot] = 0;
				abort_total = abort_total + 1;
			end
		end
		cnt = 0;
		for (int i = 0; i < N; i++) cnt += ent_valid[i];
		if (cnt > 127) cnt = 127;
		r.finished_count = fin_total;
		r.aborted_count = abort_total;
		r.open_sessions = cnt[6:0];
		pending_results.push_back(r);
	endfunction

	function void check_result(tst_pkg::res_t got);
		tst_pkg::res_t exp_r;
		if (pending_results.size() == 0) begin
			$error("unexpected result %h", got);
			errors++;
			return;
		end
		exp_r = pending_results.pop_front();
		if (got.status !== exp_r.status) begin
			$error("status exp %0d got %0d", exp_r.status, got.status);
			errors++;
		end
		if (got.finished_count !== exp_r.finished_count) begin
			$error("finished_count exp %0d got %0d", exp_r.finished_count,
				got.finished_count);
			errors++;
		end
		if (got.aborted_count !== exp_r.aborted_count) begin
			$error("aborted_count exp %0d got %0d", exp_r.aborted_count,
				got.aborted_count);
			errors++;
		end
		if (got.open_sessions !== exp_r.open_sessions) begin
			$error("open_sessions exp %0d got %0d", exp_r.open_sessions,
				got.open_sessions);
			errors++;
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// two lookup passes at most per header, plus long stalls
	localparam int IDLE_LIMIT = 20000;
	localparam int N_RANDOM = 1730;

	logic clk = 0;
	logic arst_n = 0;
	tst_pkg::pkt_t pkt = '0;
	logic pkt_valid = 0;
	logic pkt_stall;
	tst_pkg::res_t res;
	logic res_valid;
	logic res_stall = 0;

	session_scoreboard sb = new();
	bit stim_done = 0;
	int idle_cycles = 0;
	int rx_gap;
	int rx_left = 0;

	// small pool of hosts so random headers collide with live sessions
	logic [31:0] host_ip [4] = '{32'h0a000001, 32'h0a000002, 32'hffffffff, 32'h0};
	logic [15:0] host_port [4] = '{16'd80, 16'd443, 16'hffff, 16'd0};

	tcp_session_tracker dut (
		.clk(clk), .arst_n(arst_n),
		.pkt(pkt), .pkt_valid(pkt_valid), .pkt_stall(pkt_stall),
		.res(res), .res_valid(res_valid), .res_stall(res_stall)
	);

	always #1 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 150);
	endfunction

	// send one header; holds valid across back-to-back items
	task automatic send_header(tst_pkg::pkt_t p);
		int g;
		g = gap_len();
		if (g > 0) begin
			pkt_valid <= 0;
			repeat (g) @(posedge clk);
		end
		pkt <= p;
		pkt_valid <= 1;
		@(posedge clk);
		while (pkt_stall) @(posedge clk);
		sb.note_header(p);
	endtask

	task automatic send_fields(logic [31:0] sip, logic [31:0] dip, logic [15:0] sp,
		logic [15:0] dp, logic [31:0] sq, logic [31:0] ak, logic [7:0] fl);
		tst_pkg::pkt_t p;
		p.src_ip = sip; p.dst_ip = dip; p.src_port = sp; p.dst_port = dp;
		p.seq_num = sq; p.ack_num = ak; p.tcp_flags = fl;
		send_header(p);
	endtask

	task automatic drain();
		pkt_valid <= 0;
		@(posedge clk);
		while (sb.pending_results.size() != 0) @(posedge clk);
	endtask

	// a full open/close sequence, sometimes broken or aborted
	task automatic session_run(int mode);
		logic [31:0] a, b, sa, sb_seq;
		logic [15:0] pa, pb;
		a = host_ip[$urandom_range(0, 3)];
		b = ($urandom_range(0, 1)) ? host_ip[$urandom_range(0, 3)] : $urandom;
		pa = host_port[$urandom_range(0, 3)];
		pb = ($urandom_range(0, 1)) ? 16'($urandom) : 16'hffff;
		sa = ($urandom_range(0, 7) == 0) ? 32'hffffffff : $urandom;
		sb_seq = $urandom;
		send_fields(a, b, pa, pb, sa, $urandom, tst_pkg::FL_SYN);
		send_fields(b, a, pb, pa, sb_seq, (mode == 1) ? $urandom : sa + 1,
			tst_pkg::FL_SYN | tst_pkg::FL_ACK);
		send_fields(a, b, pa, pb, sa + 1, sb_seq + 1, tst_pkg::FL_ACK);
		if (mode == 2) begin
			send_fields(b, a, pb, pa, $urandom, $urandom,
				tst_pkg::FL_RST | (8'($urandom) & 8'h10));
			return;
		end
		send_fields(a, b, pa, pb, sa + 5, sb_seq + 1, tst_pkg::FL_FIN | tst_pkg::FL_ACK);
		send_fields(b, a, pb, pa, sb_seq + 1, (mode == 3) ? $urandom : sa + 6,
			tst_pkg::FL_FIN | tst_pkg::FL_ACK);
		send_fields(a, b, pa, pb, sa + 6, sb_seq + 2, tst_pkg::FL_ACK);
	endtask

	initial begin
		tst_pkg::pkt_t p;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: clean close, abort, oddball flag mixes, field extremes
		session_run(0);
		session_run(2);
		send_fields('0, '0, '0, '0, '0, '0, 8'h00);
		send_fields('1, '1, '1, '1, '1, '1, 8'hff);
		send_fields('1, '0, '1, '0, '1, '0, tst_pkg::FL_SYN | tst_pkg::FL_RST);
		send_fields(32'h1, 32'h2, 16'h3, 16'h4, 32'hffffffff, 32'h0, tst_pkg::FL_SYN);
		send_fields(32'h2, 32'h1, 16'h4, 16'h3, 32'h5, 32'h0,
			tst_pkg::FL_SYN | tst_pkg::FL_ACK);
		send_fields(32'h1, 32'h2, 16'h3, 16'h4, 32'h0, 32'h6, tst_pkg::FL_ACK);
		send_fields(32'h2, 32'h1, 16'h4, 16'h3, 32'h6, 32'h9,
			tst_pkg::FL_FIN | tst_pkg::FL_RST);
		drain();

		// fill the table to overflow, then a few dropped SYNs
		for (int i = 0; i < tst_pkg::ENTRIES_DEF + 3; i++)
			send_fields(32'hc0a80000 + i, 32'h08080808, 16'(i), 16'd53, $urandom,
				$urandom, tst_pkg::FL_SYN);
		// tear the flood down by RST
		for (int i = 0; i < tst_pkg::ENTRIES_DEF; i++)
			send_fields(32'h08080808, 32'hc0a80000 + i, 16'd53, 16'(i), $urandom,
				$urandom, tst_pkg::FL_RST);
		drain();

		for (int n = 0; n < N_RANDOM; ) begin
			if ($urandom_range(0, 99) < 60) begin
				session_run($urandom_range(0, 3));
				n += 6;
			end else begin
				p = ($urandom_range(0, 7) == 0) ? '1 :
					{$urandom, $urandom, 16'($urandom), 16'($urandom), $urandom,
					$urandom, 8'($urandom)};
				p.src_ip = $urandom_range(0, 1) ? host_ip[$urandom_range(0, 3)] : $urandom;
				p.dst_ip = $urandom_range(0, 1) ? host_ip[$urandom_range(0, 3)] : $urandom;
				p.src_port = host_port[$urandom_range(0, 3)];
				p.tcp_flags = 8'($urandom);
				send_header(p);
				n++;
			end
			// pause for a full drain once in a while
			if ($urandom_range(0, 99) == 0) drain();
		end
		pkt_valid <= 0;
		stim_done = 1;
	end

	// receiver: stall runs of random length, result checked at accept
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) sb.check_result(res);
			if (rx_left > 0) begin
				res_stall <= 1'b1;
				rx_left <= rx_left - 1;
			end else begin
				rx_gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
				res_stall <= (rx_gap > 0);
				rx_left <= (rx_gap > 0) ? rx_gap - 1 : 0;
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if ((pkt_valid && !pkt_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/tst_pkg.sv
design/tst_ram.sv
design/tst_front.sv
design/tst_back.sv
design/tcp_session_tracker.sv
test/tb_top.sv
